/* hw/rtl/ifs_pkg.sv */
// Package for the information frame stuffing transmitter.
// Holds payload structs, the internal job struct, line constants and stuffing helpers.
// No dependencies.
package ifs_pkg;

   localparam logic [7:0] FLAG_BYTE     = 8'h7E;
   localparam logic [7:0] ESC_BYTE      = 8'h7D;
   localparam logic [7:0] ESC_FLAG      = 8'h5E;
   localparam logic [7:0] ESC_ESC       = 8'h5D;
   localparam logic [7:0] CTRL_SEQ1     = 8'h40;
   localparam logic [7:0] CTRL_SEQ0     = 8'h00;
   localparam logic [7:0] ADDRESS_RESET = 8'h03;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W   = 3;
   localparam logic REG_ADDRESS_BYTE = 1'b0;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       first_byte;
      logic       last_byte;
      logic       seq_bit;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       frame_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] data;
      logic       first_byte;
      logic       last_byte;
      logic       seq_bit;
      logic [7:0] check;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    empty;
      logic    full;
      job_type head;
   } queue_status_type;

   function automatic logic needs_escape(input logic [7:0] value);
      needs_escape = (value == FLAG_BYTE) || (value == ESC_BYTE);
   endfunction

   function automatic logic [7:0] escape_code(input logic [7:0] value);
      escape_code = (value == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
   endfunction

endpackage

/* hw/rtl/ifs_front.sv */
// Front end: accepts payload items, keeps the running payload check, builds jobs.
// Depends on ifs_pkg; feeds ifs_queue.
module ifs_front
   import ifs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_payload_type  req_payload,
   input  logic             queue_full,
   output push_type         push
);

   logic [7:0] check_ff;
   logic [7:0] check_in;
   logic [7:0] check_new;
   logic       accept;

   always_comb begin
      accept    = req_valid && !queue_full;
      check_new = (req_payload.first_byte ? 8'h00 : check_ff) ^ req_payload.payload_byte;
      check_in  = check_ff;
      if (accept) begin
         check_in = req_payload.last_byte ? 8'h00 : check_new;
      end
      push.valid           = accept;
      push.job.data        = req_payload.payload_byte;
      push.job.first_byte  = req_payload.first_byte;
      push.job.last_byte   = req_payload.last_byte;
      push.job.seq_bit     = req_payload.seq_bit;
      push.job.check       = check_new;
   end

   assign req_stall = queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         check_ff <= 8'h00;
      end else begin
         check_ff <= check_in;
      end
   end

endmodule

/* hw/rtl/ifs_queue.sv */
// Short job queue between front end and back end.
// Depends on ifs_pkg.
module ifs_queue
   import ifs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output queue_status_type status
);

   job_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_CNT_W-1:0]   count_in;
   logic                     do_push;
   logic                     do_pop;

   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
      status.head  = entry_ff[rd_ptr_ff];
      do_push      = push.valid && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

/* hw/rtl/ifs_back.sv */
// Back end: per job, header if first, stuffed data, stuffed check and closing flag if last.
// Depends on ifs_pkg; drains ifs_queue and drives the registered result channel.
module ifs_back
   import ifs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       address_byte,
   input  queue_status_type status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_payload_type  rsp_payload
);

   localparam logic [3:0] PH_FLAG = 4'd0;
   localparam logic [3:0] PH_ADDR = 4'd1;
   localparam logic [3:0] PH_CTRL = 4'd2;
   localparam logic [3:0] PH_HCS  = 4'd3;
   localparam logic [3:0] PH_DATA = 4'd4;
   localparam logic [3:0] PH_DAT2 = 4'd5;
   localparam logic [3:0] PH_CHK  = 4'd6;
   localparam logic [3:0] PH_CHK2 = 4'd7;
   localparam logic [3:0] PH_END  = 4'd8;

   logic            busy_ff;
   logic            busy_in;
   logic [3:0]      phase_ff;
   logic [3:0]      phase_in;
   job_type         job_ff;
   job_type         job_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_payload_in;

   job_type         sel_job;
   logic [3:0]      sel_phase;
   logic [3:0]      next_phase;
   logic            slot_free;
   logic            work;
   logic            finish;
   logic [7:0]      ctrl;
   logic [7:0]      out_byte;
   logic            out_done;

   always_comb begin
      slot_free = !rsp_valid_ff || !rsp_stall;
      sel_job   = busy_ff ? job_ff : status.head;
      sel_phase = busy_ff ? phase_ff : (status.head.first_byte ? PH_FLAG : PH_DATA);
      work      = slot_free && (busy_ff || !status.empty);
      pop       = slot_free && !busy_ff && !status.empty;
      ctrl      = sel_job.seq_bit ? CTRL_SEQ1 : CTRL_SEQ0;

      out_byte   = FLAG_BYTE;
      out_done   = 1'b0;
      next_phase = PH_END;
      finish     = 1'b0;
      unique case (sel_phase)
         PH_FLAG: begin
            out_byte   = FLAG_BYTE;
            next_phase = PH_ADDR;
         end
         PH_ADDR: begin
            out_byte   = address_byte;
            next_phase = PH_CTRL;
         end
         PH_CTRL: begin
            out_byte   = ctrl;
            next_phase = PH_HCS;
         end
         PH_HCS: begin
            out_byte   = address_byte ^ ctrl;
            next_phase = PH_DATA;
         end
         PH_DATA: begin
            if (needs_escape(sel_job.data)) begin
               out_byte   = ESC_BYTE;
               next_phase = PH_DAT2;
            end else begin
               out_byte   = sel_job.data;
               next_phase = PH_CHK;
               finish     = !sel_job.last_byte;
            end
         end
         PH_DAT2: begin
            out_byte   = escape_code(sel_job.data);
            next_phase = PH_CHK;
            finish     = !sel_job.last_byte;
         end
         PH_CHK: begin
            if (needs_escape(sel_job.check)) begin
               out_byte   = ESC_BYTE;
               next_phase = PH_CHK2;
            end else begin
               out_byte   = sel_job.check;
               next_phase = PH_END;
            end
         end
         PH_CHK2: begin
            out_byte   = escape_code(sel_job.check);
            next_phase = PH_END;
         end
         PH_END: begin
            out_byte = FLAG_BYTE;
            out_done = 1'b1;
            finish   = 1'b1;
         end
         default: begin
            finish = 1'b1;
         end
      endcase

      busy_in        = busy_ff;
      phase_in       = phase_ff;
      job_in         = job_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (slot_free) begin
         rsp_valid_in = work;
      end
      if (work) begin
         busy_in                   = !finish;
         phase_in                  = next_phase;
         job_in                    = sel_job;
         rsp_payload_in.line_byte  = out_byte;
         rsp_payload_in.frame_done = out_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_FLAG;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff         <= job_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* hw/rtl/info_frame_stuffing_transmitter.sv */
// Information frame transmitter with byte stuffing: top level and address register.
// Depends on ifs_pkg, ifs_front, ifs_queue and ifs_back.
//
// Usage: each req_ item carries one raw payload byte with first/last marks and the
// sequence bit. A first byte opens the frame with flag, address, control and header
// check; every payload byte and the closing check are stuffed (0x7E -> 0x7D 0x5E,
// 0x7D -> 0x7D 0x5D); a last byte is followed by the check and a closing flag with
// frame_done set. rsp_ items are single line bytes.
// Throughput: one line byte per cycle from the back-end sequencer while rsp_stall is
// low; an item yields 1 to 9 line bytes, a payload byte two when stuffed, else one.
// A four-entry job queue lets the front end keep accepting while the sequencer works.
// Accepted items pass through the job queue; line bytes leave from an output register.
// The address register sits at byte address 0 of the csr_ port (reset 0x03).
// Reset clears the running check, the queue and the output register.
// When rsp_stall is high the output byte holds; the queue absorbs up to four items,
// then req_stall rises.
module info_frame_stuffing_transmitter
   import ifs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [7:0]       address_ff;
   logic [7:0]       address_in;
   logic             csr_write;
   push_type         push;
   logic             pop;
   queue_status_type status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_ADDRESS_BYTE);

   always_comb begin
      address_in = csr_write ? csr_pwdata[7:0] : address_ff;
      csr_prdata = (csr_paddr[2] == REG_ADDRESS_BYTE) ? {24'h000000, address_ff} : 32'h0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= ADDRESS_RESET;
      end else begin
         address_ff <= address_in;
      end
   end

   ifs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (status.full),
      .push        (push)
   );

   ifs_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (status)
   );

   ifs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .address_byte (address_ff),
      .status       (status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

   a_done_is_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_done |-> rsp_payload.line_byte == FLAG_BYTE)
      else $error("frame_done on a byte other than the closing flag");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("sequencer popped an empty job queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !status.full)
      else $error("front end pushed into a full job queue");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Testbench for info_frame_stuffing_transmitter: directed table, then random frames under
// several address settings and stall patterns, checked against typed bytes or a stuffing predictor.
// Depends on ifs_pkg and the block's RTL; reads no files.
module tb;
   import ifs_pkg::*;

   localparam int PHASES = 9;
   localparam int ITEMS_PER_PHASE = 25;
   localparam int LONG_HOLD = 80;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [CSR_ADDR_W-1:0] ADDRESS_REG_ADDR = CSR_ADDR_W'(4 * REG_ADDRESS_BYTE);

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      req_payload_type item;
      logic [3:0]      typed_count;
      logic [71:0]     typed_line;
   } directed_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   idle_mode_type    idle_mode = IDLE_NONE;
   int               hold_request = 0;
   int               mismatch_count = 0;
   logic [7:0]       address_shadow = ADDRESS_RESET;
   logic [7:0]       running_check = 8'h00;
   rsp_payload_type  line_bytes_due [$];
   rsp_payload_type  line_out [9];
   int               line_count;
   directed_row_type directed_table [$];

   info_frame_stuffing_transmitter DUT (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic void put_line(input logic [7:0] value, input logic done);
      line_out[line_count].line_byte = value;
      line_out[line_count].frame_done = done;
      line_count++;
   endfunction

   function automatic void put_stuffed(input logic [7:0] value);
      if (value == FLAG_BYTE) begin
         put_line(ESC_BYTE, 1'b0);
         put_line(ESC_FLAG, 1'b0);
      end else if (value == ESC_BYTE) begin
         put_line(ESC_BYTE, 1'b0);
         put_line(ESC_ESC, 1'b0);
      end else begin
         put_line(value, 1'b0);
      end
   endfunction

   function automatic void stuff_item(input req_payload_type item);
      logic [7:0] ctrl;
      line_count = 0;
      if (item.first_byte) begin
         ctrl = item.seq_bit ? CTRL_SEQ1 : CTRL_SEQ0;
         put_line(FLAG_BYTE, 1'b0);
         put_line(address_shadow, 1'b0);
         put_line(ctrl, 1'b0);
         put_line(address_shadow ^ ctrl, 1'b0);
         running_check = 8'h00;
      end
      running_check = running_check ^ item.payload_byte;
      put_stuffed(item.payload_byte);
      if (item.last_byte) begin
         put_stuffed(running_check);
         put_line(FLAG_BYTE, 1'b1);
         running_check = 8'h00;
      end
   endfunction

   task automatic queue_expected(input req_payload_type item, input int typed_count,
                                 input logic [71:0] typed_line);
      rsp_payload_type entry;
      int k;
      stuff_item(item);
      if (typed_count == 0) begin
         for (k = 0; k < line_count; k++) line_bytes_due.push_back(line_out[k]);
      end else begin
         for (k = 0; k < typed_count; k++) begin
            entry.line_byte = typed_line[71 - 8 * k -: 8];
            entry.frame_done = item.last_byte && (k == typed_count - 1);
            line_bytes_due.push_back(entry);
         end
      end
   endtask

   function automatic directed_row_type make_row(input logic [7:0] value, input logic first,
                                                 input logic last, input logic seq,
                                                 input int count, input logic [71:0] line);
      directed_row_type row;
      row.item.payload_byte = value;
      row.item.first_byte = first;
      row.item.last_byte = last;
      row.item.seq_bit = seq;
      row.typed_count = 4'(count);
      row.typed_line = line;
      return row;
   endfunction

   function automatic logic sender_idles();
      return (idle_mode == IDLE_SENDER && $urandom_range(99) < 56) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < 7);
   endfunction

   function automatic logic receiver_stalls();
      return (idle_mode == IDLE_RECEIVER && $urandom_range(99) < 56) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < 7);
   endfunction

   task automatic offer_item(input req_payload_type item);
      while (sender_idles()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (line_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_address(input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDRESS_REG_ADDR;
      csr_pwdata <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      address_shadow = value;
      @(posedge clock);
   endtask

   task automatic read_address();
      logic [31:0] value;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= ADDRESS_REG_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      value = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (value[7:0] !== address_shadow)
         report_mismatch("address readback", value[7:0], address_shadow);
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_payload();
      int roll;
      roll = $urandom_range(99);
      if (roll < 20) return FLAG_BYTE;
      if (roll < 40) return ESC_BYTE;
      return 8'($urandom_range(255));
   endfunction

   task automatic send_random_frame(inout int sent);
      req_payload_type item;
      logic [7:0] frame_xor;
      int body;
      int k;
      logic abandon;
      if ($urandom_range(99) < 15) begin
         item = 11'($urandom);
         offer_item(item);
         queue_expected(item, 0, '0);
         sent++;
         return;
      end
      body = ($urandom_range(99) < 20) ? 0 : $urandom_range(6, 1);
      abandon = ($urandom_range(99) < 10);
      frame_xor = 8'h00;
      for (k = 0; k <= body; k++) begin
         item.first_byte = (k == 0);
         item.last_byte = (k == body) && !abandon;
         item.seq_bit = 1'($urandom_range(1));
         item.payload_byte = pick_payload();
         // steer the check byte onto a code that must be escaped
         if (item.last_byte && $urandom_range(99) < 25)
            item.payload_byte = frame_xor ^ ($urandom_range(1) ? FLAG_BYTE : ESC_BYTE);
         frame_xor = frame_xor ^ item.payload_byte;
         offer_item(item);
         queue_expected(item, 0, '0);
         sent++;
      end
   endtask

   initial begin
      rsp_payload_type due;
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (line_bytes_due.size() == 0) begin
               report_mismatch("unexpected line byte", rsp_payload.line_byte, 8'h00);
            end else begin
               due = line_bytes_due.pop_front();
               if (rsp_payload.line_byte !== due.line_byte)
                  report_mismatch("line_byte", rsp_payload.line_byte, due.line_byte);
               if (rsp_payload.frame_done !== due.frame_done)
                  report_mismatch("frame_done", 8'(rsp_payload.frame_done),
                                  8'(due.frame_done));
            end
         end
         if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= receiver_stalls();
         end
      end
   end

   initial begin
      int sent;
      int ph;
      int r;
      logic [7:0] phase_address;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;

      // one-byte frames at the reset address
      directed_table.push_back(make_row(8'h00, 1'b1, 1'b1, 1'b0, 7,
                                        72'h7E_03_00_03_00_00_7E_00_00));
      directed_table.push_back(make_row(8'hFF, 1'b1, 1'b1, 1'b1, 7,
                                        72'h7E_03_40_43_FF_FF_7E_00_00));
      directed_table.push_back(make_row(8'h7E, 1'b1, 1'b1, 1'b0, 9,
                                        72'h7E_03_00_03_7D_5E_7D_5E_7E));
      directed_table.push_back(make_row(8'h7D, 1'b1, 1'b1, 1'b1, 9,
                                        72'h7E_03_40_43_7D_5D_7D_5D_7E));
      // bytes with no opening first
      directed_table.push_back(make_row(8'h55, 1'b0, 1'b0, 1'b0, 0, '0));
      directed_table.push_back(make_row(8'h01, 1'b0, 1'b0, 1'b1, 0, '0));
      directed_table.push_back(make_row(8'h2A, 1'b0, 1'b1, 1'b0, 0, '0));
      // frame with escaped payload
      directed_table.push_back(make_row(8'h7E, 1'b1, 1'b0, 1'b1, 0, '0));
      directed_table.push_back(make_row(8'h7D, 1'b0, 1'b0, 1'b0, 0, '0));
      directed_table.push_back(make_row(8'h80, 1'b0, 1'b1, 1'b1, 0, '0));
      // abandon an open frame, then close with an escaped check
      directed_table.push_back(make_row(8'h11, 1'b1, 1'b0, 1'b0, 0, '0));
      directed_table.push_back(make_row(8'h22, 1'b0, 1'b0, 1'b0, 0, '0));
      directed_table.push_back(make_row(8'h33, 1'b1, 1'b0, 1'b1, 0, '0));
      directed_table.push_back(make_row(8'h4E, 1'b0, 1'b1, 1'b0, 0, '0));
      // last with nothing before it
      directed_table.push_back(make_row(8'h00, 1'b0, 1'b1, 1'b0, 0, '0));
      directed_table.push_back(make_row(8'hAA, 1'b1, 1'b0, 1'b0, 0, '0));
      directed_table.push_back(make_row(8'hD4, 1'b0, 1'b1, 1'b1, 0, '0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_address();
      for (r = 0; r < directed_table.size(); r++) begin
         offer_item(directed_table[r].item);
         queue_expected(directed_table[r].item, int'(directed_table[r].typed_count),
                        directed_table[r].typed_line);
      end
      drain();

      for (ph = 1; ph < PHASES; ph++) begin
         case (ph)
            1: phase_address = FLAG_BYTE;
            2: phase_address = 8'h00;
            3: phase_address = 8'hFF;
            4: phase_address = ESC_BYTE;
            5: phase_address = 8'h3D;
            6: phase_address = 8'h3E;
            default: phase_address = 8'($urandom_range(255));
         endcase
         write_address(phase_address);
         read_address();
         idle_mode = idle_mode_type'(ph % 4);
         if (ph == 4) hold_request++;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) send_random_frame(sent);
         drain();
      end

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
